// File: rtl/core/ac3_sync_frame_header_parser_unit_assert.svh
// Assertion macros for the AC-3 header parser.
`ifndef AC3_SYNC_FRAME_HEADER_PARSER_UNIT_ASSERT_SVH
`define AC3_SYNC_FRAME_HEADER_PARSER_UNIT_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define AC3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define AC3_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/core/ac3_pkg.sv
// Shared types, constants and frame size table for the AC-3 header parser.
`timescale 1ns / 1ps
package ac3_pkg;
  localparam int unsigned OffsetBitsDefault = 32;
  localparam logic [7:0] SyncHi = 8'h0B;
  localparam logic [7:0] SyncLo = 8'h77;
  localparam logic [5:0] NumSizeCodes = 6'd38;

  typedef enum logic [1:0] {
    PH_SKIP_START = 2'd0,
    PH_HUNT       = 2'd1,
    PH_HEADER     = 2'd2,
    PH_FRAME      = 2'd3
  } phase_e;

  // Header bytes captured by the front part, handed to the back part.
  typedef struct packed {
    logic [31:0] offset;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [7:0]  b4;
    logic [7:0]  b5;
  } hdr_raw_t;

  // Decoded record; packs to tdata with frame_offset lowest.
  typedef struct packed {
    logic        header_valid;
    logic        lfe_present;
    logic [2:0]  channel_mode;
    logic [2:0]  service_mode;
    logic [4:0]  stream_id;
    logic [10:0] frame_words;
    logic [5:0]  size_code;
    logic [1:0]  rate_code;
    logic [15:0] crc_word;
    logic [31:0] frame_offset;
  } hdr_rec_t;

  // A/52 frame words at 48 kHz; 44.1 kHz tabled, 32 kHz derived below.
  function automatic logic [10:0] size_48k(input logic [4:0] idx);
    logic [10:0] w;
    case (idx)
      5'd0: w = 11'd64;    5'd1: w = 11'd80;    5'd2: w = 11'd96;
      5'd3: w = 11'd112;   5'd4: w = 11'd128;   5'd5: w = 11'd160;
      5'd6: w = 11'd192;   5'd7: w = 11'd224;   5'd8: w = 11'd256;
      5'd9: w = 11'd320;   5'd10: w = 11'd384;  5'd11: w = 11'd448;
      5'd12: w = 11'd512;  5'd13: w = 11'd640;  5'd14: w = 11'd768;
      5'd15: w = 11'd896;  5'd16: w = 11'd1024; 5'd17: w = 11'd1152;
      5'd18: w = 11'd1280;
      default: w = 11'd0;
    endcase
    return w;
  endfunction

  function automatic logic [10:0] size_44k(input logic [5:0] sz);
    logic [10:0] w;
    case (sz[5:1])
      5'd0: w = 11'd69;    5'd1: w = 11'd87;    5'd2: w = 11'd104;
      5'd3: w = 11'd121;   5'd4: w = 11'd139;   5'd5: w = 11'd174;
      5'd6: w = 11'd208;   5'd7: w = 11'd243;   5'd8: w = 11'd278;
      5'd9: w = 11'd348;   5'd10: w = 11'd417;  5'd11: w = 11'd487;
      5'd12: w = 11'd557;  5'd13: w = 11'd696;  5'd14: w = 11'd835;
      5'd15: w = 11'd975;  5'd16: w = 11'd1114; 5'd17: w = 11'd1253;
      5'd18: w = 11'd1393;
      default: w = 11'd0;
    endcase
    return w + {10'd0, sz[0]};
  endfunction

  function automatic logic [10:0] frame_size(input logic [1:0] fs, input logic [5:0] sz);
    logic [10:0] base;
    logic [10:0] w;
    base = size_48k(sz[5:1]);
    case (fs)
      2'd0: w = base;
      2'd1: w = size_44k(sz);
      2'd2: w = base + {1'b0, base[10:1]};
      default: w = 11'd0;
    endcase
    return w;
  endfunction
endpackage

// File: rtl/core/ac3_front.sv
// Front part: start skip, sync hunt, header byte capture and frame skip.
`timescale 1ns / 1ps
module ac3_front #(
  parameter int unsigned OffsetBits = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       start_skip_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  output logic              hdr_valid_o,
  input  logic              hdr_ready_i,
  output ac3_pkg::hdr_raw_t hdr_o,
  input  logic              skip_valid_i,
  input  logic [11:0]       skip_len_i
);
  import ac3_pkg::*;
  `include "ac3_sync_frame_header_parser_unit_assert.svh"

  phase_e phase_q, phase_d;
  logic [7:0] last_q, last_d;
  logic last_vld_q, last_vld_d;
  logic [2:0] cnt_q, cnt_d;
  logic [31:0] skip_q, skip_d;
  logic [OffsetBits-1:0] pos_q;
  logic [7:0] hb_q [5];
  logic [31:0] off_q;
  logic wait_q, wait_d;
  logic acc;

  // Stall while a header waits for its decode result (frame length), and hold
  // the sixth header byte while the record queue has no room.
  assign in_ready_o = !wait_q && !(phase_q == PH_HEADER && cnt_q == 3'd5 && !hdr_ready_i);
  assign acc = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    phase_e ph;
    ph = phase_q;
    phase_d = phase_q;
    last_d = last_q;
    last_vld_d = last_vld_q;
    cnt_d = cnt_q;
    skip_d = skip_q;
    wait_d = wait_q;
    if (wait_q && skip_valid_i) begin
      wait_d = 1'b0;
      if (skip_len_i != 12'd0) begin
        phase_d = PH_FRAME;
        skip_d = {20'd0, skip_len_i};
      end else begin
        phase_d = PH_HUNT;
        last_vld_d = 1'b0;
        last_d = 8'd0;
      end
    end else if (acc) begin
      if (ph == PH_SKIP_START) begin
        if (skip_q < start_skip_i) skip_d = skip_q + 32'd1;
        else begin
          ph = PH_HUNT;
          last_vld_d = 1'b0;
        end
      end
      phase_d = ph;
      case (ph)
        PH_HUNT: begin
          if ((last_vld_q || phase_q == PH_HUNT) && last_vld_d && last_q == SyncHi
              && in_byte_i == SyncLo) begin
            phase_d = PH_HEADER;
            cnt_d = 3'd0;
          end else begin
            last_d = in_byte_i;
            last_vld_d = 1'b1;
          end
        end
        PH_HEADER: begin
          if (cnt_q == 3'd5) begin
            cnt_d = 3'd0;
            wait_d = 1'b1;
          end else cnt_d = cnt_q + 3'd1;
        end
        PH_FRAME: begin
          skip_d = skip_q - 32'd1;
          if (skip_q == 32'd1) begin
            phase_d = PH_HUNT;
            last_vld_d = 1'b0;
            last_d = 8'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP_START;
      last_q <= 8'd0;
      last_vld_q <= 1'b0;
      cnt_q <= 3'd0;
      skip_q <= 32'd0;
      pos_q <= '0;
      wait_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      last_q <= last_d;
      last_vld_q <= last_vld_d;
      cnt_q <= cnt_d;
      skip_q <= skip_d;
      wait_q <= wait_d;
      if (acc) pos_q <= pos_q + {{(OffsetBits-1){1'b0}}, 1'b1};
    end
  end

  // header capture; offset of sync byte is position minus two at first header byte
  always_ff @(posedge clk_i) begin
    if (acc && phase_q == PH_HEADER && cnt_q != 3'd5) hb_q[cnt_q] <= in_byte_i;
    if (acc && phase_q == PH_HEADER && cnt_q == 3'd0) begin
      off_q <= 32'(pos_q - OffsetBits'(2));
    end
  end

  // Record handed to the back part on the sixth header byte.
  logic sent_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sent_q <= 1'b0;
    else sent_q <= acc && phase_q == PH_HEADER && cnt_q == 3'd5;
  end
  logic [7:0] b5_q;
  always_ff @(posedge clk_i) begin
    if (acc && phase_q == PH_HEADER && cnt_q == 3'd5) b5_q <= in_byte_i;
  end

  assign hdr_valid_o = sent_q;
  always_comb begin
    hdr_o = '{offset: off_q, b0: hb_q[0], b1: hb_q[1], b2: hb_q[2], b3: hb_q[3],
              b4: hb_q[4], b5: b5_q};
  end

  `AC3_ASSERT_IMP(a_no_accept_waiting, wait_q, !in_ready_o)
  `AC3_ASSERT_NXT(a_wait_after_sixth, acc && phase_q == PH_HEADER && cnt_q == 3'd5, wait_q)
  `AC3_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= 3'd5)
endmodule

// File: rtl/core/ac3_back.sv
// Back part: header decode, two-entry result queue and output stage.
`timescale 1ns / 1ps
module ac3_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              hdr_ready_o,
  input  ac3_pkg::hdr_raw_t hdr_i,
  output logic              skip_valid_o,
  output logic [11:0]       skip_len_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ac3_pkg::hdr_rec_t rec_o
);
  import ac3_pkg::*;
  `include "ac3_sync_frame_header_parser_unit_assert.svh"

  hdr_rec_t dec;
  logic [2:0] acm;
  logic [15:0] bits;
  logic vld;

  // decode
  always_comb begin
    acm = hdr_i.b4[7:5];
    bits = {hdr_i.b4[4:0], hdr_i.b5, 3'd0};
    if (acm[0] && acm != 3'd1) bits = bits << 2;
    if (acm[2]) bits = bits << 2;
    if (acm == 3'd2) bits = bits << 2;
    vld = hdr_i.b2[7:6] != 2'd3 && hdr_i.b2[5:0] < NumSizeCodes;
    dec.frame_offset = hdr_i.offset;
    dec.crc_word = {hdr_i.b0, hdr_i.b1};
    dec.rate_code = hdr_i.b2[7:6];
    dec.size_code = hdr_i.b2[5:0];
    dec.frame_words = vld ? frame_size(hdr_i.b2[7:6], hdr_i.b2[5:0]) : 11'd0;
    dec.stream_id = hdr_i.b3[7:3];
    dec.service_mode = hdr_i.b3[2:0];
    dec.channel_mode = acm;
    dec.lfe_present = bits[15];
    dec.header_valid = vld;
  end

  assign skip_valid_o = push_i;
  assign skip_len_o = dec.header_valid ? {dec.frame_words, 1'b0} - 12'd8 : 12'd0;

  // two-entry queue toward the master side
  hdr_rec_t q_q [2];
  logic [1:0] cnt_q;
  logic rd_q, wr_q;
  logic pop;
  assign out_valid_o = cnt_q != 2'd0;
  assign pop = out_valid_o && out_ready_i;
  assign rec_o = q_q[rd_q];
  // room for the one header that can be in flight from the front part
  assign hdr_ready_o = cnt_q != 2'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) q_q[wr_q] <= dec;
  end

  `AC3_ASSERT_IMP(a_no_overflow, push_i, cnt_q != 2'd2 || pop)
  `AC3_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= 2'd2)
  `AC3_ASSERT_IMP(a_words_zero_bad, push_i && !dec.header_valid, dec.frame_words == 11'd0)
endmodule

// File: rtl/core/ac3_sync_frame_header_parser_unit.sv
// Top level of the AC-3 sync frame header parser.
// A record is offered once the sixth header byte's record has passed the sent register and the queue.
// Throughput: 1 byte per cycle, except a stall after each header
//   while the decoded frame length is fed back to the skip counter.
// Records buffer in a 2-entry queue; the sixth header byte waits while it is full.
// Reset (rst_ni low, async) clears all control state; start_skip resets to 0.
`timescale 1ns / 1ps
module ac3_sync_frame_header_parser_unit #(
  parameter int unsigned OffsetBits = ac3_pkg::OffsetBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // frame_offset, crc_word, rate_code, size_code, frame_words, stream_id,
  // service_mode, channel_mode, lfe_present, header_valid, then zero pad
  output logic [87:0]  m_axis_tdata
);
  import ac3_pkg::*;

  logic [31:0] start_skip_q;
  hdr_raw_t raw;
  hdr_rec_t rec;
  logic push, hdr_rdy, skv;
  logic [11:0] skl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) start_skip_q <= 32'd0;
    else if (cfg_we_i) start_skip_q <= cfg_wdata_i;
  end

  // front part; holds the sixth header byte while the queue may not take another record
  ac3_front #(.OffsetBits(OffsetBits)) u_front (
    .clk_i, .rst_ni, .start_skip_i(start_skip_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_byte_i(s_axis_tdata),
    .hdr_valid_o(push), .hdr_ready_i(hdr_rdy), .hdr_o(raw),
    .skip_valid_i(skv), .skip_len_i(skl)
  );

  ac3_back u_back (
    .clk_i, .rst_ni, .push_i(push), .hdr_ready_o(hdr_rdy), .hdr_i(raw),
    .skip_valid_o(skv), .skip_len_o(skl),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .rec_o(rec)
  );
  assign m_axis_tdata = {8'd0, rec};
endmodule
